// ----- hdl/net_bounding_box_wirelength_unit_defines.svh -----
// Assertion macros for the net bounding-box wirelength unit.
// No dependencies; included by the top level only.
`ifndef NET_BOUNDING_BOX_WIRELENGTH_UNIT_DEFINES_SVH
`define NET_BOUNDING_BOX_WIRELENGTH_UNIT_DEFINES_SVH

// Implication checked on every edge outside reset.
`define NBBW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Implication checked on every edge, reset included.
`define NBBW_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hdl/nbbw_pkg.sv -----
// Shared types and constants of the net bounding-box wirelength unit.
// No dependencies.
package nbbw_pkg;

    localparam int unsigned COORD_W        = 32;
    localparam int unsigned WEIGHT_W       = 16;
    localparam int unsigned WEIGHT_FRAC    = 8;
    localparam int unsigned PROD_W         = COORD_W + WEIGHT_W;
    localparam int unsigned ADD_W          = PROD_W - WEIGHT_FRAC + 1;
    localparam int unsigned COUNT_BITS_DEF = 10;
    localparam int unsigned COST_BITS_DEF  = 48;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;

    // Per-axis update control for one accepted pin.
    typedef struct packed {
        logic take;   // pin grows the box
        logic first;  // no pin of this net taken yet
        logic clear;  // net ends, return box state to zero
    } t_axis_ctl;

endpackage

// ----- hdl/net_bounding_box_wirelength_unit.sv -----
// Net bounding-box wirelength unit: top level with pin intake and box tracking.
// Depends on nbbw_pkg, nbbw_axis, nbbw_cost and the assertion macro header.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one pin per request: x, y,
//   pin_skip, net_skip, last_pin, restart. A request is taken at an edge
//   with i_valid high and o_stall low. Pins of one net come back to back;
//   last_pin marks the end of the net.
//   Output channel (o_valid / i_stall) carries one request per net whose last
//   pin is not net-skipped: box, edge counts, width, height, running cost and
//   box_valid. It is taken at an edge with o_valid high and i_stall low.
//   Throughput: one pin per cycle, sustained while o_stall is low, including nets of one pin.
//   Pipeline: five register stages (box capture at the edge that takes a net's
//   last pin, extent, 16x32 multiply, net cost, saturating accumulate/output);
//   o_valid rises when the result enters the output stage.
//   Stall: i_stall holds the output register; the pipeline keeps filling
//   behind it and o_stall rises once the box capture stage can not move.
//   Reset (synchronous, i_rst_n low): pipeline empties, box state and the
//   running cost go to zero, vertical weight returns to 1.0 (Q8.8 256).
//   Configuration: i_cfg_we writes the vertical weight; write it idle only.
`include "net_bounding_box_wirelength_unit_defines.svh"

module net_bounding_box_wirelength_unit #(
    parameter int unsigned COUNT_BITS = nbbw_pkg::COUNT_BITS_DEF,
    parameter int unsigned COST_BITS  = nbbw_pkg::COST_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [nbbw_pkg::WEIGHT_W-1:0]        i_cfg_wdata,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [nbbw_pkg::COORD_W-1:0]  i_pin_x,
    input  logic signed [nbbw_pkg::COORD_W-1:0]  i_pin_y,
    input  logic                                 i_pin_skip,
    input  logic                                 i_net_skip,
    input  logic                                 i_last_pin,
    input  logic                                 i_restart,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [nbbw_pkg::COORD_W-1:0]  o_box_xmin,
    output logic signed [nbbw_pkg::COORD_W-1:0]  o_box_xmax,
    output logic signed [nbbw_pkg::COORD_W-1:0]  o_box_ymin,
    output logic signed [nbbw_pkg::COORD_W-1:0]  o_box_ymax,
    output logic [COUNT_BITS-1:0]                o_left_count,
    output logic [COUNT_BITS-1:0]                o_right_count,
    output logic [COUNT_BITS-1:0]                o_bottom_count,
    output logic [COUNT_BITS-1:0]                o_top_count,
    output logic [nbbw_pkg::COORD_W-1:0]         o_half_width,
    output logic [nbbw_pkg::COORD_W-1:0]         o_half_height,
    output logic [COST_BITS-1:0]                 o_total_cost,
    output logic                                 o_box_valid
);
    import nbbw_pkg::*;

    logic [WEIGHT_W-1:0] r_weight;

    // intake control
    logic      accept, take, res_in, free_a, cost_free;
    t_axis_ctl axis_ctl;
    logic      r_have_pin, n_have_pin;
    logic      r_rst_pend, n_rst_pend;

    // next box values from the axis trackers
    logic signed [COORD_W-1:0] xmin_n, xmax_n, ymin_n, ymax_n;
    logic [COUNT_BITS-1:0]     left_n, right_n, bottom_n, top_n;

    // box capture stage
    logic                      r_a_vld, r_a_rst, r_a_bvld;
    logic signed [COORD_W-1:0] r_a_xmin, r_a_xmax, r_a_ymin, r_a_ymax;
    logic [4*COUNT_BITS-1:0]   r_a_cnt;

    // take a request whenever the capture stage is empty or draining
    assign free_a  = !r_a_vld || cost_free;
    assign o_stall = !free_a;
    assign accept  = i_valid && free_a;

    // a net-skip flag drops its own pin; on a last pin it also drops the net's result
    assign take   = accept && !i_pin_skip && !i_net_skip;
    assign res_in = accept && i_last_pin && !i_net_skip;

    assign axis_ctl = '{take: take, first: !r_have_pin, clear: accept && i_last_pin};

    assign n_have_pin = (accept && i_last_pin) ? 1'b0 : (take ? 1'b1 : r_have_pin);

    // hold a restart seen on a request without result until the next result
    always_comb begin
        n_rst_pend = r_rst_pend;
        if (accept) begin
            n_rst_pend = res_in ? 1'b0 : (r_rst_pend || i_restart);
        end
    end

    nbbw_axis #(
        .COUNT_BITS (COUNT_BITS)
    ) u_axis_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (axis_ctl),
        .i_coord    (i_pin_x),
        .o_min_n    (xmin_n),
        .o_max_n    (xmax_n),
        .o_lo_cnt_n (left_n),
        .o_hi_cnt_n (right_n)
    );

    nbbw_axis #(
        .COUNT_BITS (COUNT_BITS)
    ) u_axis_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (axis_ctl),
        .i_coord    (i_pin_y),
        .o_min_n    (ymin_n),
        .o_max_n    (ymax_n),
        .o_lo_cnt_n (bottom_n),
        .o_hi_cnt_n (top_n)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight   <= WEIGHT_RESET;
            r_have_pin <= 1'b0;
            r_rst_pend <= 1'b0;
            r_a_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_weight <= i_cfg_wdata;
            end
            r_have_pin <= n_have_pin;
            r_rst_pend <= n_rst_pend;
            if (free_a) begin
                r_a_vld <= res_in;
            end
        end
    end

    // capture the finished box; an empty net reads all zero here
    always_ff @(posedge i_clk) begin
        if (res_in) begin
            r_a_rst  <= i_restart || r_rst_pend;
            r_a_bvld <= r_have_pin || take;
            r_a_xmin <= xmin_n;
            r_a_xmax <= xmax_n;
            r_a_ymin <= ymin_n;
            r_a_ymax <= ymax_n;
            r_a_cnt  <= {top_n, bottom_n, right_n, left_n};
        end
    end

    nbbw_cost #(
        .COUNT_BITS (COUNT_BITS),
        .COST_BITS  (COST_BITS)
    ) u_cost (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_weight       (r_weight),
        .i_valid        (r_a_vld),
        .o_free         (cost_free),
        .i_restart      (r_a_rst),
        .i_box_valid    (r_a_bvld),
        .i_xmin         (r_a_xmin),
        .i_xmax         (r_a_xmax),
        .i_ymin         (r_a_ymin),
        .i_ymax         (r_a_ymax),
        .i_counts       (r_a_cnt),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_box_xmin     (o_box_xmin),
        .o_box_xmax     (o_box_xmax),
        .o_box_ymin     (o_box_ymin),
        .o_box_ymax     (o_box_ymax),
        .o_left_count   (o_left_count),
        .o_right_count  (o_right_count),
        .o_bottom_count (o_bottom_count),
        .o_top_count    (o_top_count),
        .o_half_width   (o_half_width),
        .o_half_height  (o_half_height),
        .o_total_cost   (o_total_cost),
        .o_box_valid    (o_box_valid)
    );

    // empty net carries a zero box
    `NBBW_ASSERT_IMPL(a_empty_net_zero, o_valid && !o_box_valid, o_half_width == '0 && o_half_height == '0 && o_left_count == '0 && o_top_count == '0, "empty net with nonzero box")
    // real box is ordered, width matches, left and bottom edges hold a pin
    `NBBW_ASSERT_IMPL(a_box_sane, o_valid && o_box_valid, o_box_xmin <= o_box_xmax && o_box_ymin <= o_box_ymax && o_half_width == COORD_W'(o_box_xmax - o_box_xmin) && o_left_count != '0 && o_bottom_count != '0, "inconsistent net box")
    // stall only with a full capture stage
    `NBBW_ASSERT_IMPL(a_stall_needs_full, o_stall, r_a_vld, "stall with empty capture stage")
    // reset clears result and cost
    `NBBW_ASSERT_ALWAYS(a_reset_clears, $past(!i_rst_n), !o_valid && o_total_cost == '0, "reset left state behind")

endmodule

// ----- hdl/nbbw_axis.sv -----
// One axis of the bounding-box tracker: min/max edges and edge pin counts.
// Depends on nbbw_pkg.
module nbbw_axis #(
    parameter int unsigned COUNT_BITS = nbbw_pkg::COUNT_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  nbbw_pkg::t_axis_ctl                      i_ctl,
    input  logic signed [nbbw_pkg::COORD_W-1:0]      i_coord,
    output logic signed [nbbw_pkg::COORD_W-1:0]      o_min_n,
    output logic signed [nbbw_pkg::COORD_W-1:0]      o_max_n,
    output logic        [COUNT_BITS-1:0]             o_lo_cnt_n,
    output logic        [COUNT_BITS-1:0]             o_hi_cnt_n
);
    import nbbw_pkg::*;

    logic signed [COORD_W-1:0] r_min, r_max, n_min, n_max;
    logic [COUNT_BITS-1:0]     r_lo, r_hi, n_lo, n_hi, lo_inc, hi_inc;

    assign lo_inc = (&r_lo) ? r_lo : r_lo + COUNT_BITS'(1);
    assign hi_inc = (&r_hi) ? r_hi : r_hi + COUNT_BITS'(1);

    always_comb begin
        n_min = r_min;
        n_max = r_max;
        n_lo  = r_lo;
        n_hi  = r_hi;
        if (i_ctl.take) begin
            if (i_ctl.first) begin
                n_min = i_coord;
                n_max = i_coord;
                n_lo  = COUNT_BITS'(1);
                n_hi  = COUNT_BITS'(1);
            end else if (i_coord < r_min) begin
                n_min = i_coord;
                n_lo  = COUNT_BITS'(1);
            end else if (i_coord == r_min) begin
                // a pin on both edges bumps both counts
                n_lo = lo_inc;
                if (i_coord == r_max) begin
                    n_hi = hi_inc;
                end
            end else if (i_coord > r_max) begin
                n_max = i_coord;
                n_hi  = COUNT_BITS'(1);
            end else if (i_coord == r_max) begin
                n_hi = hi_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_min <= '0;
            r_max <= '0;
            r_lo  <= '0;
            r_hi  <= '0;
        end else begin
            r_min <= n_min;
            r_max <= n_max;
            r_lo  <= n_lo;
            r_hi  <= n_hi;
        end
    end

    assign o_min_n    = n_min;
    assign o_max_n    = n_max;
    assign o_lo_cnt_n = n_lo;
    assign o_hi_cnt_n = n_hi;

endmodule

// ----- hdl/nbbw_cost.sv -----
// Cost pipeline: extent, weighted multiply, net cost, saturating running sum.
// Depends on nbbw_pkg.
module nbbw_cost #(
    parameter int unsigned COUNT_BITS = nbbw_pkg::COUNT_BITS_DEF,
    parameter int unsigned COST_BITS  = nbbw_pkg::COST_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [nbbw_pkg::WEIGHT_W-1:0]        i_weight,
    input  logic                                 i_valid,
    output logic                                 o_free,
    input  logic                                 i_restart,
    input  logic                                 i_box_valid,
    input  logic signed [nbbw_pkg::COORD_W-1:0]  i_xmin,
    input  logic signed [nbbw_pkg::COORD_W-1:0]  i_xmax,
    input  logic signed [nbbw_pkg::COORD_W-1:0]  i_ymin,
    input  logic signed [nbbw_pkg::COORD_W-1:0]  i_ymax,
    input  logic [4*COUNT_BITS-1:0]              i_counts,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [nbbw_pkg::COORD_W-1:0]  o_box_xmin,
    output logic signed [nbbw_pkg::COORD_W-1:0]  o_box_xmax,
    output logic signed [nbbw_pkg::COORD_W-1:0]  o_box_ymin,
    output logic signed [nbbw_pkg::COORD_W-1:0]  o_box_ymax,
    output logic [COUNT_BITS-1:0]                o_left_count,
    output logic [COUNT_BITS-1:0]                o_right_count,
    output logic [COUNT_BITS-1:0]                o_bottom_count,
    output logic [COUNT_BITS-1:0]                o_top_count,
    output logic [nbbw_pkg::COORD_W-1:0]         o_half_width,
    output logic [nbbw_pkg::COORD_W-1:0]         o_half_height,
    output logic [COST_BITS-1:0]                 o_total_cost,
    output logic                                 o_box_valid
);
    import nbbw_pkg::*;

    localparam int unsigned SUM_W = ((COST_BITS > ADD_W) ? COST_BITS : ADD_W) + 1;
    localparam logic [SUM_W-1:0] CMAX = SUM_W'({COST_BITS{1'b1}});

    typedef struct packed {
        logic                      rst;
        logic                      bvld;
        logic signed [COORD_W-1:0] xmin;
        logic signed [COORD_W-1:0] xmax;
        logic signed [COORD_W-1:0] ymin;
        logic signed [COORD_W-1:0] ymax;
        logic [4*COUNT_BITS-1:0]   cnt;
    } t_box;

    t_box in_box;
    t_box r_b_box, r_c_box, r_d_box, r_o_box;
    logic r_b_vld, r_c_vld, r_d_vld, r_o_vld;
    logic free_b, free_c, free_d, free_o;

    logic [COORD_W-1:0] r_b_w, r_b_h, r_c_w, r_o_w, r_o_h, r_c_h, r_d_w, r_d_h;
    logic [PROD_W-1:0]  r_c_prod;
    logic [ADD_W-1:0]   r_d_add;
    logic [COST_BITS-1:0] r_cost, n_cost, base;
    logic [SUM_W-1:0]   sum;

    assign in_box = '{rst: i_restart, bvld: i_box_valid, xmin: i_xmin, xmax: i_xmax,
                      ymin: i_ymin, ymax: i_ymax, cnt: i_counts};

    // each stage moves when the one after it is empty or moving
    assign free_o = !r_o_vld || !i_stall;
    assign free_d = !r_d_vld || free_o;
    assign free_c = !r_c_vld || free_d;
    assign free_b = !r_b_vld || free_c;
    assign o_free = free_b;

    // saturating running cost; restart zeroes the base first
    assign base   = r_d_box.rst ? '0 : r_cost;
    assign sum    = SUM_W'(base) + SUM_W'(r_d_add);
    assign n_cost = (sum > CMAX) ? {COST_BITS{1'b1}} : sum[COST_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_o_vld <= 1'b0;
            r_cost  <= '0;
        end else begin
            if (free_b) begin
                r_b_vld <= i_valid;
            end
            if (free_c) begin
                r_c_vld <= r_b_vld;
            end
            if (free_d) begin
                r_d_vld <= r_c_vld;
            end
            if (free_o) begin
                r_o_vld <= r_d_vld;
                if (r_d_vld) begin
                    r_cost <= n_cost;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free_b && i_valid) begin
            r_b_box <= in_box;
            r_b_w   <= COORD_W'(i_xmax - i_xmin);
            r_b_h   <= COORD_W'(i_ymax - i_ymin);
        end
        if (free_c && r_b_vld) begin
            r_c_box  <= r_b_box;
            r_c_w    <= r_b_w;
            r_c_h    <= r_b_h;
            r_c_prod <= PROD_W'(i_weight) * PROD_W'(r_b_h);
        end
        if (free_d && r_c_vld) begin
            r_d_box <= r_c_box;
            r_d_w   <= r_c_w;
            r_d_h   <= r_c_h;
            r_d_add <= ADD_W'(r_c_w) + ADD_W'(r_c_prod[PROD_W-1:WEIGHT_FRAC]);
        end
        if (free_o && r_d_vld) begin
            r_o_box <= r_d_box;
            r_o_w   <= r_d_w;
            r_o_h   <= r_d_h;
        end
    end

    assign o_valid        = r_o_vld;
    assign o_box_xmin     = r_o_box.xmin;
    assign o_box_xmax     = r_o_box.xmax;
    assign o_box_ymin     = r_o_box.ymin;
    assign o_box_ymax     = r_o_box.ymax;
    assign o_left_count   = r_o_box.cnt[0*COUNT_BITS +: COUNT_BITS];
    assign o_right_count  = r_o_box.cnt[1*COUNT_BITS +: COUNT_BITS];
    assign o_bottom_count = r_o_box.cnt[2*COUNT_BITS +: COUNT_BITS];
    assign o_top_count    = r_o_box.cnt[3*COUNT_BITS +: COUNT_BITS];
    assign o_half_width   = r_o_w;
    assign o_half_height  = r_o_h;
    assign o_total_cost   = r_cost;
    assign o_box_valid    = r_o_box.bvld;

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for net_bounding_box_wirelength_unit: net bounding box, edge counts,
// weighted half-perimeter cost. Depends on nbbw_pkg and the RTL top level only.
// Stimulus: directed table, one very long net, random phases at several weights, a saturation run.
module tb_top;

    import nbbw_pkg::*;

    localparam int unsigned CNT_W        = COUNT_BITS_DEF;
    localparam int unsigned COST_W       = COST_BITS_DEF;
    localparam logic [63:0] COST_MAX     = (64'd1 << COST_W) - 64'd1;
    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;
    localparam int          DRAIN_CYCLES = 12;   // margin for the pipeline to run dry
    localparam int          QUIET_LIMIT  = 1000; // cycles without any accepted request
    localparam int          LONG_NET     = 1030; // past the 1023 count ceiling
    localparam int          SAT_NETS     = 258;  // about 2^40 per net, 2^48 ceiling
    localparam int          PHASE_PINS   = 12;   // pins per random weight phase

    // Edge counter slots, ordered as the result lists them.
    typedef enum int {SIDE_LEFT, SIDE_RIGHT, SIDE_BOTTOM, SIDE_TOP} t_side;

    // How random pin coordinates of one net are spread.
    typedef enum int {SPREAD_FULL, SPREAD_CLUSTER, SPREAD_EXTREME} t_spread;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      pin_skip;
        logic                      net_skip;
        logic                      last_pin;
        logic                      restart;
    } t_pin;

    typedef struct packed {
        logic signed [COORD_W-1:0] xmin;
        logic signed [COORD_W-1:0] xmax;
        logic signed [COORD_W-1:0] ymin;
        logic signed [COORD_W-1:0] ymax;
        logic [CNT_W-1:0]          n_left;
        logic [CNT_W-1:0]          n_right;
        logic [CNT_W-1:0]          n_bottom;
        logic [CNT_W-1:0]          n_top;
        logic [COORD_W-1:0]        width;
        logic [COORD_W-1:0]        height;
        logic [COST_W-1:0]         cost;
        logic                      valid;
    } t_net_box;

    // One line of the directed table; want is used only when typed is set.
    typedef struct {
        t_pin     pin;
        bit       typed;
        t_net_box want;
    } t_stim_row;

    // ------------------------------------------------------------------
    // Clock and DUT signals
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [WEIGHT_W-1:0]       i_cfg_wdata;
    logic                      i_valid;
    logic                      o_stall;
    logic signed [COORD_W-1:0] i_pin_x;
    logic signed [COORD_W-1:0] i_pin_y;
    logic                      i_pin_skip;
    logic                      i_net_skip;
    logic                      i_last_pin;
    logic                      i_restart;
    logic                      o_valid;
    logic                      i_stall;
    logic signed [COORD_W-1:0] o_box_xmin;
    logic signed [COORD_W-1:0] o_box_xmax;
    logic signed [COORD_W-1:0] o_box_ymin;
    logic signed [COORD_W-1:0] o_box_ymax;
    logic [CNT_W-1:0]          o_left_count;
    logic [CNT_W-1:0]          o_right_count;
    logic [CNT_W-1:0]          o_bottom_count;
    logic [CNT_W-1:0]          o_top_count;
    logic [COORD_W-1:0]        o_half_width;
    logic [COORD_W-1:0]        o_half_height;
    logic [COST_W-1:0]         o_total_cost;
    logic                      o_box_valid;

    net_bounding_box_wirelength_unit #(
        .COUNT_BITS (CNT_W),
        .COST_BITS  (COST_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pin_x        (i_pin_x),
        .i_pin_y        (i_pin_y),
        .i_pin_skip     (i_pin_skip),
        .i_net_skip     (i_net_skip),
        .i_last_pin     (i_last_pin),
        .i_restart      (i_restart),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_box_xmin     (o_box_xmin),
        .o_box_xmax     (o_box_xmax),
        .o_box_ymin     (o_box_ymin),
        .o_box_ymax     (o_box_ymax),
        .o_left_count   (o_left_count),
        .o_right_count  (o_right_count),
        .o_bottom_count (o_bottom_count),
        .o_top_count    (o_top_count),
        .o_half_width   (o_half_width),
        .o_half_height  (o_half_height),
        .o_total_cost   (o_total_cost),
        .o_box_valid    (o_box_valid)
    );

    // ------------------------------------------------------------------
    // Box predictor: shadow copy of the net state, the cost and the weight
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] bx_lo, bx_hi, by_lo, by_hi;
    logic [CNT_W-1:0]          on_edge [4];
    bit                        have_pin;
    logic [63:0]               run_cost;
    logic [WEIGHT_W-1:0]       v_weight;

    t_net_box pending_boxes[$];   // nets whose result is still due, oldest first
    t_stim_row stim_rows[$];

    int  pins_sent;
    int  nets_checked;
    int  weights_used;
    int  mismatches;
    int  quiet_cycles;
    int  rx_hold;
    bit  tx_burst;
    bit  rx_burst;

    function automatic void clear_box();
        bx_lo = '0;
        bx_hi = '0;
        by_lo = '0;
        by_hi = '0;
        foreach (on_edge[i]) on_edge[i] = '0;
        have_pin = 1'b0;
    endfunction

    // Count one more pin on an edge, holding at the counter ceiling.
    function automatic void bump(input t_side s);
        if (on_edge[s] != {CNT_W{1'b1}}) on_edge[s] = on_edge[s] + 1'b1;
    endfunction

    function automatic void take_pin(input logic signed [COORD_W-1:0] x,
                                     input logic signed [COORD_W-1:0] y);
        if (!have_pin) begin
            // First real pin of the net opens the box on every side.
            bx_lo = x;
            bx_hi = x;
            by_lo = y;
            by_hi = y;
            foreach (on_edge[i]) on_edge[i] = CNT_W'(1);
            have_pin = 1'b1;
            return;
        end
        // A tie with the low edge also counts on the high edge when the
        // box is flat along that axis; a new extreme restarts its count.
        if (x < bx_lo) begin
            bx_lo = x;
            on_edge[SIDE_LEFT] = CNT_W'(1);
        end else if (x == bx_lo) begin
            bump(SIDE_LEFT);
            if (x == bx_hi) bump(SIDE_RIGHT);
        end else if (x > bx_hi) begin
            bx_hi = x;
            on_edge[SIDE_RIGHT] = CNT_W'(1);
        end else if (x == bx_hi) begin
            bump(SIDE_RIGHT);
        end
        if (y < by_lo) begin
            by_lo = y;
            on_edge[SIDE_BOTTOM] = CNT_W'(1);
        end else if (y == by_lo) begin
            bump(SIDE_BOTTOM);
            if (y == by_hi) bump(SIDE_TOP);
        end else if (y > by_hi) begin
            by_hi = y;
            on_edge[SIDE_TOP] = CNT_W'(1);
        end else if (y == by_hi) begin
            bump(SIDE_TOP);
        end
    endfunction

    // Advance the shadow state by one accepted pin; returns 1 when the pin
    // closes a net that reports, with the expected result in res.
    function automatic bit absorb_pin(input t_pin p, output t_net_box res);
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic [63:0]        add;
        res = '0;
        if (p.restart) run_cost = '0;
        if (!p.pin_skip && !p.net_skip) take_pin(p.x, p.y);
        if (!p.last_pin) return 1'b0;
        if (p.net_skip) begin
            clear_box();
            return 1'b0;
        end
        if (have_pin) begin
            w   = bx_hi - bx_lo;
            h   = by_hi - by_lo;
            add = 64'(w) + ((64'(v_weight) * 64'(h)) >> WEIGHT_FRAC);
            if (add > COST_MAX - run_cost) run_cost = COST_MAX;
            else run_cost = run_cost + add;
            res.xmin     = bx_lo;
            res.xmax     = bx_hi;
            res.ymin     = by_lo;
            res.ymax     = by_hi;
            res.n_left   = on_edge[SIDE_LEFT];
            res.n_right  = on_edge[SIDE_RIGHT];
            res.n_bottom = on_edge[SIDE_BOTTOM];
            res.n_top    = on_edge[SIDE_TOP];
            res.width    = w;
            res.height   = h;
            res.valid    = 1'b1;
        end
        res.cost = run_cost[COST_W-1:0];
        clear_box();
        return 1'b1;
    endfunction

    function automatic t_pin mk_pin(input logic signed [COORD_W-1:0] x,
                                    input logic signed [COORD_W-1:0] y,
                                    input bit ps, input bit ns, input bit lp, input bit rs);
        t_pin p;
        p.x        = x;
        p.y        = y;
        p.pin_skip = ps;
        p.net_skip = ns;
        p.last_pin = lp;
        p.restart  = rs;
        return p;
    endfunction

    function automatic t_net_box mk_box(input logic signed [COORD_W-1:0] xmin, xmax, ymin, ymax,
                                        input int l, r, b, t,
                                        input logic [COORD_W-1:0] w, h,
                                        input logic [63:0] cost, input bit valid);
        t_net_box n;
        n.xmin     = xmin;
        n.xmax     = xmax;
        n.ymin     = ymin;
        n.ymax     = ymax;
        n.n_left   = CNT_W'(l);
        n.n_right  = CNT_W'(r);
        n.n_bottom = CNT_W'(b);
        n.n_top    = CNT_W'(t);
        n.width    = w;
        n.height   = h;
        n.cost     = cost[COST_W-1:0];
        n.valid    = valid;
        return n;
    endfunction

    function automatic void row(input t_pin p);
        stim_rows.push_back('{p, 1'b0, '0});
    endfunction

    function automatic void row_sure(input t_pin p, input t_net_box want);
        stim_rows.push_back('{p, 1'b1, want});
    endfunction

    // Wait drawn per item: none inside a burst, else a uniform random draw.
    function automatic int draw_wait(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 9));
    endfunction

    function automatic logic signed [COORD_W-1:0] draw_coord(input t_spread mode,
                                                             input logic signed [COORD_W-1:0] base);
        case (mode)
            SPREAD_FULL:    return $urandom;
            SPREAD_CLUSTER: return base + $signed(32'($urandom_range(0, 6))) - 32'sd3;
            default: begin
                case ($urandom_range(0, 6))
                    0:       return C_MIN;
                    1:       return C_MIN + 32'sd1;
                    2:       return -32'sd1;
                    3:       return 32'sd0;
                    4:       return 32'sd1;
                    5:       return C_MAX - 32'sd1;
                    default: return C_MAX;
                endcase
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request driver: inputs move on the falling edge, acceptance is seen
    // on the rising edge. Every task below starts and ends at a falling edge.
    // ------------------------------------------------------------------
    task automatic send_pin(input t_pin p, input bit typed = 1'b0, input t_net_box want = '0);
        t_net_box res;
        int       gap;
        gap = draw_wait(tx_burst);
        // Drop valid only when a gap follows, so a back-to-back request keeps
        // valid high with a single assignment in this step.
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_pin_x    <= p.x;
        i_pin_y    <= p.y;
        i_pin_skip <= p.pin_skip;
        i_net_skip <= p.net_skip;
        i_last_pin <= p.last_pin;
        i_restart  <= p.restart;
        do @(posedge i_clk); while (o_stall);
        if (absorb_pin(p, res)) pending_boxes.push_back(typed ? want : res);
        pins_sent++;
        @(negedge i_clk);
    endtask

    // Hold off the sender until every due net has come back, then let the
    // pipeline run dry (a net-skipped tail leaves no result to wait for).
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_boxes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_weight(input logic [WEIGHT_W-1:0] w);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        v_weight     = w;
        weights_used++;
    endtask

    task automatic send_random_net();
        t_pin                      p;
        int                        npins;
        t_spread                   mode;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        // Mostly short nets, now and then a longer one.
        npins = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        mode  = t_spread'($urandom_range(0, 2));
        cx    = $urandom;
        cy    = $urandom;
        if ($urandom_range(0, 24) == 0) tx_burst = !tx_burst;
        for (int i = 0; i < npins; i++) begin
            p.x        = draw_coord(mode, cx);
            p.y        = draw_coord(mode, cy);
            p.pin_skip = ($urandom_range(0, 6) == 0);
            p.last_pin = (i == npins - 1);
            p.net_skip = p.last_pin ? ($urandom_range(0, 11) == 0) : ($urandom_range(0, 19) == 0);
            p.restart  = ($urandom_range(0, 39) == 0);
            send_pin(p);
        end
    endtask

    task automatic run_phase(input logic [WEIGHT_W-1:0] w, input int n_pins);
        int start;
        settle();
        set_weight(w);
        start = pins_sent;
        while (pins_sent - start < n_pins) begin
            send_random_net();
            // Occasionally let the output side empty completely mid-phase.
            if ($urandom_range(0, 29) == 0) settle();
        end
    endtask

    // Maximum weight and full-span two-pin nets drive the cost into its ceiling.
    task automatic run_saturation();
        t_pin lo_pin;
        t_pin hi_pin;
        settle();
        set_weight({WEIGHT_W{1'b1}});
        for (int n = 0; n < SAT_NETS; n++) begin
            lo_pin = mk_pin(C_MIN, C_MIN, 1'b0, 1'b0, 1'b0, n == 0);
            hi_pin = mk_pin(C_MAX, C_MAX, 1'b0, 1'b0, 1'b0, n == 0);
            if ($urandom_range(0, 1) == 1) begin
                hi_pin.last_pin = 1'b1;
                hi_pin.restart  = 1'b0;
                send_pin(lo_pin);
                send_pin(hi_pin);
            end else begin
                lo_pin.last_pin = 1'b1;
                lo_pin.restart  = 1'b0;
                send_pin(hi_pin);
                send_pin(lo_pin);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker and receiver stall
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_net_box want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_boxes.size() == 0) begin
                $error("net result arrived with no net outstanding");
                mismatches++;
            end else begin
                want = pending_boxes.pop_front();
                check_field("box_xmin",     want.xmin,     o_box_xmin);
                check_field("box_xmax",     want.xmax,     o_box_xmax);
                check_field("box_ymin",     want.ymin,     o_box_ymin);
                check_field("box_ymax",     want.ymax,     o_box_ymax);
                check_field("left_count",   want.n_left,   o_left_count);
                check_field("right_count",  want.n_right,  o_right_count);
                check_field("bottom_count", want.n_bottom, o_bottom_count);
                check_field("top_count",    want.n_top,    o_top_count);
                check_field("half_width",   want.width,    o_half_width);
                check_field("half_height",  want.height,   o_half_height);
                check_field("total_cost",   want.cost,     o_total_cost);
                check_field("box_valid",    want.valid,    o_box_valid);
            end
            nets_checked++;
            // Draw how long to stall before taking the next result.
            rx_hold = draw_wait(rx_burst);
            if ($urandom_range(0, 24) == 0) rx_burst = !rx_burst;
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_stall <= 1'b1;
            rx_hold--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog: end the run when no request moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_valid      = 1'b0;
        i_pin_x      = '0;
        i_pin_y      = '0;
        i_pin_skip   = 1'b0;
        i_net_skip   = 1'b0;
        i_last_pin   = 1'b0;
        i_restart    = 1'b0;
        i_stall      = 1'b0;
        pins_sent    = 0;
        nets_checked = 0;
        weights_used = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        rx_hold      = 0;
        tx_burst     = 1'b0;
        rx_burst     = 1'b0;
        v_weight     = WEIGHT_RESET;
        run_cost     = '0;
        clear_box();

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, reset weight of 1.0 and cost starting at zero.
        // Single pin at the origin: zero-size box, every edge count one.
        row_sure(mk_pin(0, 0, 0, 0, 1, 0), mk_box(0, 0, 0, 0, 1, 1, 1, 1, 0, 0, 0, 1));
        // Opposite corners of the coordinate range: full-span width and height.
        row(mk_pin(C_MIN, C_MIN, 0, 0, 0, 0));
        row_sure(mk_pin(C_MAX, C_MAX, 0, 0, 1, 0),
                 mk_box(C_MIN, C_MAX, C_MIN, C_MAX, 1, 1, 1, 1,
                        32'hffff_ffff, 32'hffff_ffff, 64'h1_ffff_fffe, 1));
        // Net with its only pin skipped: invalid box, cost unchanged.
        row_sure(mk_pin(5, 7, 1, 0, 1, 0), mk_box(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 64'h1_ffff_fffe, 0));
        // Cost cleared on the last pin itself, then the net is added.
        row_sure(mk_pin(1, 1, 0, 0, 1, 1), mk_box(1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 1));
        // Net skip on an inner pin only drops that pin.
        row(mk_pin(3, 3, 0, 1, 0, 0));
        row_sure(mk_pin(4, -4, 0, 0, 1, 0), mk_box(4, 4, -4, -4, 1, 1, 1, 1, 0, 0, 0, 1));
        // Net skip on the last pin: no result, box state cleared for the next net.
        row(mk_pin(10, 10, 0, 0, 0, 0));
        row(mk_pin(20, 20, 0, 1, 1, 0));
        row(mk_pin(2, 3, 0, 0, 1, 0));
        // Edge ties, flat-box double counting and count restart on a new extreme.
        row(mk_pin(5, 5, 0, 0, 0, 0));
        row(mk_pin(5, 5, 0, 0, 0, 0));
        row(mk_pin(5, 9, 0, 0, 0, 0));
        row(mk_pin(9, 5, 0, 0, 0, 0));
        row(mk_pin(7, 7, 0, 0, 1, 0));
        // Restart on an inner pin.
        row(mk_pin(0, 0, 0, 0, 0, 1));
        row(mk_pin(-6, 2, 0, 0, 1, 0));
        // Restart together with a net-skipped last pin: cost cleared, no result.
        row(mk_pin(8, 8, 0, 1, 1, 1));
        row(mk_pin(0, 100, 0, 0, 0, 0));
        row(mk_pin(0, -100, 0, 0, 1, 0));
        // Several skipped pins in one net.
        row(mk_pin(-1, -1, 1, 0, 0, 0));
        row(mk_pin(7, 7, 1, 0, 1, 0));
        foreach (stim_rows[i]) send_pin(stim_rows[i].pin, stim_rows[i].typed, stim_rows[i].want);

        // One net with every pin on the same point drives all four counts
        // into their ceiling.
        for (int i = 0; i < LONG_NET; i++) begin
            send_pin(mk_pin(-12345, 678, 0, 0, i == LONG_NET - 1, 0));
        end

        // Random phases across the weight range, extremes included, with a saturation run.
        run_phase(16'd0, PHASE_PINS);
        run_saturation();
        run_phase(16'd1, PHASE_PINS);
        run_phase(16'($urandom), PHASE_PINS);
        run_phase(16'h8000, PHASE_PINS);
        run_phase(16'($urandom), PHASE_PINS);
        run_phase(16'hffff, PHASE_PINS);
        run_phase(WEIGHT_RESET, PHASE_PINS);

        settle();
        $display("Covered %0d pins, %0d net results checked, %0d vertical weight settings.",
                 pins_sent, nets_checked, weights_used);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
